// ===== hdl/smma_pkg.sv =====
// Shared types and constants for the scaled matrix multiply-accumulate block.
package smma_pkg;

    // Widths of the item fields.
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned VAL_W    = 16;
    localparam int unsigned SIZE_W   = 6;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IX_W = 2;
    localparam int unsigned TDATA_W  = 32;
    localparam int unsigned OPA_W    = VAL_W + 1;
    localparam int unsigned PROD_W   = OPA_W + VAL_W;

    // Q4.12 fractional bits dropped after scaling (12 from the product, 12 from alpha).
    localparam int unsigned FRAC_DROP = 24;
    localparam int unsigned BETA_SHL  = 12;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;

    // Register reset values.
    localparam logic signed [VAL_W-1:0] ALPHA_RST = 16'sh1000;
    localparam logic signed [VAL_W-1:0] BETA_RST  = 16'sh0000;
    localparam logic [SIZE_W-1:0]       SIZE_RST  = 6'd32;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_A  = 2'd0,
        KIND_LOAD_B  = 2'd1,
        KIND_LOAD_C  = 2'd2,
        KIND_COMPUTE = 2'd3
    } t_kind;

    typedef enum logic [CFG_IX_W-1:0] {
        REG_ALPHA  = 2'd0,
        REG_BETA   = 2'd1,
        REG_SIZE   = 2'd2,
        REG_UNUSED = 2'd3
    } t_reg_idx;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic en;
    } t_mac_ctrl;

endpackage

// ===== hdl/smma_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
module smma_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/smma_mac.sv =====
// Shared multiply-accumulate unit: registered 17x16 signed product, then a shifted accumulate.
module smma_mac #(
    parameter int unsigned ACC_W = 54,
    parameter int unsigned SHW   = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  smma_pkg::t_mac_ctrl                 i_ctrl,
    input  logic signed [smma_pkg::OPA_W-1:0]   i_a,
    input  logic signed [smma_pkg::VAL_W-1:0]   i_b,
    input  logic [SHW-1:0]                      i_shift,
    output logic signed [ACC_W-1:0]             o_acc,
    output logic                                o_busy
);

    logic signed [smma_pkg::PROD_W-1:0] n_prod;
    logic signed [smma_pkg::PROD_W-1:0] r_prod;
    logic [SHW-1:0]                     r_shift;
    logic                               r_pvld;
    logic signed [ACC_W-1:0]            r_acc;
    logic signed [ACC_W-1:0]            w_addend;

    assign n_prod   = i_a * i_b;
    assign w_addend = ACC_W'(r_prod) <<< r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_ctrl.en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_shift <= i_shift;
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_pvld) begin
            r_acc <= r_acc + w_addend;
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_pvld;

endmodule

// ===== hdl/scaled_matrix_multiply_accumulate.sv =====
// Top level of the scaled matrix multiply-accumulate block, C = beta*C + alpha*(A*B).
//
// Channel    Direction  Handshake                      Contents
// s_axis     in         s_axis_tvalid / s_axis_tready  load or compute item
// m_axis     out        m_axis_tvalid / m_axis_tready  updated C element
// cfg        in         i_cfg_we (no wait)             alpha, beta, size_in_use
//
// A load item (A, B or C element) is taken and the block stays ready. A compute item keeps
// the block busy after it is taken: dot product steps through the shared multiply-accumulate
// unit, a drain of memory and multiplier latency, one pass of that same unit per 16-bit
// slice of the dot product times alpha plus one for beta*C, a drain of it, and a final
// step for rounding and write-back.
// The block is not ready during a compute item. Reset (synchronous, active low) clears the
// sequencer and restores the registers; the element stores are not cleared and hold
// whatever was last written. A stalled result sits in the output register; loads are still
// taken meanwhile, and a following compute item waits at its last step until it is taken.
module scaled_matrix_multiply_accumulate #(
    parameter int unsigned DIM = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [smma_pkg::CFG_IX_W-1:0]      i_cfg_idx,
    input  logic [smma_pkg::CFG_W-1:0]         i_cfg_data,
    // Input items.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata from bit 0: row[4:0], col[9:5], value[25:10], zero fill[31:26]
    input  logic [smma_pkg::TDATA_W-1:0]       s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [smma_pkg::KIND_W-1:0]        s_axis_tuser,
    // Result items.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata from bit 0: out_row[4:0], out_col[9:5], out_value[25:10], zero fill[31:26]
    output logic [smma_pkg::TDATA_W-1:0]       m_axis_tdata,
    // tuser: saturated[0]
    output logic                               m_axis_tuser
);

    // Store geometry and arithmetic widths derived from DIM, and the output pad width.
    localparam int unsigned DEPTH = DIM * DIM;
    localparam int unsigned AW    = (DIM > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned KW    = $clog2(DIM + 1);
    // Each product of two Q4.12 values fits 32 signed bits; DIM of them add log2(DIM) bits.
    localparam int unsigned DW    = 32 + $clog2(DIM);
    localparam int unsigned NCH   = (DW + 15) / 16;
    localparam int unsigned XW    = 16 * NCH;
    localparam int unsigned STW   = $clog2(NCH + 1);
    localparam int unsigned SHW   = $clog2(16 * (NCH - 1) + 1);
    localparam int unsigned ACC_W = DW + 17;
    localparam int unsigned RES_W = ACC_W - smma_pkg::FRAC_DROP;
    localparam int unsigned PAD_W = smma_pkg::TDATA_W - 2 * smma_pkg::IDX_W - smma_pkg::VAL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DOT,
        S_DOT_WAIT,
        S_SCALE,
        S_SCALE_WAIT,
        S_DONE
    } t_state;

    function automatic logic [AW-1:0] f_addr(input int hi, input int lo);
        return AW'(hi * DIM + lo);
    endfunction

    function automatic logic signed [smma_pkg::OPA_W-1:0] OPA_EXT(
        input logic [smma_pkg::VAL_W-1:0] v
    );
        return {v[smma_pkg::VAL_W-1], v};
    endfunction

    // Input item fields.
    logic                                 w_in_acc;
    smma_pkg::t_kind                      w_kind;
    logic [smma_pkg::IDX_W-1:0]           w_row;
    logic [smma_pkg::IDX_W-1:0]           w_col;
    logic [smma_pkg::VAL_W-1:0]           w_val;
    logic                                 w_in_range;

    // Configuration registers.
    logic signed [smma_pkg::VAL_W-1:0]    r_alpha;
    logic signed [smma_pkg::VAL_W-1:0]    r_beta;
    logic [smma_pkg::SIZE_W-1:0]          r_size;

    // Sequencer.
    t_state                               r_state;
    t_state                               n_state;
    logic [smma_pkg::IDX_W-1:0]           r_row;
    logic [smma_pkg::IDX_W-1:0]           r_col;
    logic [KW-1:0]                        r_len;
    logic [KW-1:0]                        n_len;
    logic [KW-1:0]                        r_k;
    logic [STW-1:0]                       r_step;
    logic                                 r_rd_vld;
    logic signed [DW-1:0]                 r_dot;

    // Output register.
    logic                                 r_out_vld;
    logic [smma_pkg::IDX_W-1:0]           r_out_row;
    logic [smma_pkg::IDX_W-1:0]           r_out_col;
    logic signed [smma_pkg::VAL_W-1:0]    r_out_val;
    logic                                 r_out_sat;
    logic                                 w_out_free;

    // Memories.
    logic                                 w_a_we;
    logic                                 w_b_we;
    logic                                 w_c_we;
    logic [AW-1:0]                        w_c_waddr;
    logic [smma_pkg::VAL_W-1:0]           w_c_wdata;
    logic [smma_pkg::VAL_W-1:0]           w_a_rdata;
    logic [smma_pkg::VAL_W-1:0]           w_b_rdata;
    logic [smma_pkg::VAL_W-1:0]           w_c_rdata;

    // Shared unit.
    smma_pkg::t_mac_ctrl                  w_mac_ctrl;
    logic signed [smma_pkg::OPA_W-1:0]    w_mac_a;
    logic signed [smma_pkg::VAL_W-1:0]    w_mac_b;
    logic [SHW-1:0]                       w_mac_shift;
    logic signed [ACC_W-1:0]              w_acc;
    logic                                 w_mac_busy;
    logic                                 w_drained;
    logic signed [XW-1:0]                 w_dot_x;
    logic [15:0]                          w_chunk;

    // Result formation.
    logic signed [RES_W-1:0]              w_res_full;
    logic                                 w_fits;
    logic signed [smma_pkg::VAL_W-1:0]    w_res;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_kind        = smma_pkg::t_kind'(s_axis_tuser);
    assign w_row         = s_axis_tdata[smma_pkg::IDX_W-1:0];
    assign w_col         = s_axis_tdata[2*smma_pkg::IDX_W-1:smma_pkg::IDX_W];
    assign w_val         = s_axis_tdata[2*smma_pkg::IDX_W +: smma_pkg::VAL_W];
    // Indices beyond the configured dimension make the item a no-op.
    assign w_in_range    = (int'(w_row) < DIM) && (int'(w_col) < DIM);

    // The dot product length saturates to DIM.
    assign n_len = (int'(r_size) > DIM) ? KW'(DIM) : KW'(r_size);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= smma_pkg::ALPHA_RST;
            r_beta  <= smma_pkg::BETA_RST;
            r_size  <= smma_pkg::SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (smma_pkg::t_reg_idx'(i_cfg_idx))
                smma_pkg::REG_ALPHA:  r_alpha <= i_cfg_data[smma_pkg::VAL_W-1:0];
                smma_pkg::REG_BETA:   r_beta  <= i_cfg_data[smma_pkg::VAL_W-1:0];
                smma_pkg::REG_SIZE:   r_size  <= i_cfg_data[smma_pkg::SIZE_W-1:0];
                smma_pkg::REG_UNUSED: ;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Element stores. B is kept transposed so that column j of B is a row.
    // ------------------------------------------------------------------
    assign w_out_free = !r_out_vld || m_axis_tready;

    assign w_a_we = w_in_acc && w_in_range && (w_kind == smma_pkg::KIND_LOAD_A);
    assign w_b_we = w_in_acc && w_in_range && (w_kind == smma_pkg::KIND_LOAD_B);

    // C is written by a load, or by the write-back at the end of a compute item.
    always_comb begin
        w_c_we    = 1'b0;
        w_c_waddr = f_addr(int'(w_row), int'(w_col));
        w_c_wdata = w_val;
        if (r_state == S_DONE) begin
            w_c_we    = w_out_free;
            w_c_waddr = f_addr(int'(r_row), int'(r_col));
            w_c_wdata = w_res;
        end else if (w_in_acc && w_in_range && (w_kind == smma_pkg::KIND_LOAD_C)) begin
            w_c_we = 1'b1;
        end
    end

    smma_ram #(.DEPTH(DEPTH), .AW(AW), .DW(smma_pkg::VAL_W)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (f_addr(int'(w_row), int'(w_col))),
        .i_wdata (w_val),
        .i_raddr (f_addr(int'(r_row), int'(r_k))),
        .o_rdata (w_a_rdata)
    );

    smma_ram #(.DEPTH(DEPTH), .AW(AW), .DW(smma_pkg::VAL_W)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (f_addr(int'(w_col), int'(w_row))),
        .i_wdata (w_val),
        .i_raddr (f_addr(int'(r_col), int'(r_k))),
        .o_rdata (w_b_rdata)
    );

    smma_ram #(.DEPTH(DEPTH), .AW(AW), .DW(smma_pkg::VAL_W)) u_ram_c (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_c_wdata),
        .i_raddr (f_addr(int'(r_row), int'(r_col))),
        .o_rdata (w_c_rdata)
    );

    // ------------------------------------------------------------------
    // Operand selection for the shared multiply-accumulate unit.
    // During the dot product it takes A(row,k) * B(k,col). During scaling it
    // takes alpha times one 16-bit slice of the dot product per step (lower
    // slices unsigned, the top one signed), and finally beta * C(row,col)
    // shifted up by 12 so that both terms line up with 36 fractional bits.
    // ------------------------------------------------------------------
    assign w_dot_x = XW'(r_dot);

    always_comb begin
        w_chunk = '0;
        for (int c = 0; c < NCH; c++) begin
            if (int'(r_step) == c) begin
                w_chunk = w_dot_x[16*c +: 16];
            end
        end
    end

    always_comb begin
        w_mac_a     = OPA_EXT(w_a_rdata);
        w_mac_b     = w_b_rdata;
        w_mac_shift = '0;
        if (r_state == S_SCALE) begin
            if (r_step == STW'(NCH)) begin
                w_mac_a     = OPA_EXT(w_c_rdata);
                w_mac_b     = r_beta;
                w_mac_shift = SHW'(smma_pkg::BETA_SHL);
            end else begin
                if (r_step == STW'(NCH - 1)) begin
                    w_mac_a = {w_chunk[15], w_chunk};
                end else begin
                    w_mac_a = {1'b0, w_chunk};
                end
                w_mac_b     = r_alpha;
                w_mac_shift = SHW'(int'(r_step) * 16);
            end
        end
    end

    // The unit is idle once no read is in flight and no product waits to be added.
    assign w_drained = !r_rd_vld && !w_mac_busy;

    assign w_mac_ctrl.en    = r_rd_vld || (r_state == S_SCALE);
    assign w_mac_ctrl.clear = (r_state == S_DOT_WAIT) && w_drained ||
                              (w_in_acc && (w_kind == smma_pkg::KIND_COMPUTE));

    smma_mac #(.ACC_W(ACC_W), .SHW(SHW)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mac_ctrl),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .i_shift (w_mac_shift),
        .o_acc   (w_acc),
        .o_busy  (w_mac_busy)
    );

    // ------------------------------------------------------------------
    // Rounding toward minus infinity is the arithmetic shift; then saturate.
    // ------------------------------------------------------------------
    assign w_res_full = w_acc[ACC_W-1:smma_pkg::FRAC_DROP];
    assign w_fits     = (w_res_full[RES_W-1:smma_pkg::VAL_W-1] ==
                         {(RES_W - smma_pkg::VAL_W + 1){w_res_full[smma_pkg::VAL_W-1]}});

    always_comb begin
        if (w_fits) begin
            w_res = w_res_full[smma_pkg::VAL_W-1:0];
        end else if (w_res_full[RES_W-1]) begin
            w_res = smma_pkg::VAL_MIN;
        end else begin
            w_res = smma_pkg::VAL_MAX;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_in_range && (w_kind == smma_pkg::KIND_COMPUTE)) begin
                    n_state = S_DOT;
                end
            end
            S_DOT: begin
                if (r_k == r_len) begin
                    n_state = S_DOT_WAIT;
                end
            end
            S_DOT_WAIT: begin
                if (w_drained) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                if (r_step == STW'(NCH)) begin
                    n_state = S_SCALE_WAIT;
                end
            end
            S_SCALE_WAIT: begin
                if (!w_mac_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_k       <= '0;
            r_step    <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_DOT) && (r_k != r_len);

            if (r_state == S_IDLE) begin
                r_k    <= '0;
                r_step <= '0;
                r_len  <= n_len;
                r_row  <= w_row;
                r_col  <= w_col;
            end
            if ((r_state == S_DOT) && (r_k != r_len)) begin
                r_k <= r_k + 1'b1;
            end
            if ((r_state == S_DOT_WAIT) && w_drained) begin
                r_dot <= w_acc[DW-1:0];
            end
            if (r_state == S_SCALE) begin
                r_step <= r_step + 1'b1;
            end

            if ((r_state == S_DONE) && w_out_free) begin
                r_out_vld <= 1'b1;
                r_out_row <= r_row;
                r_out_col <= r_col;
                r_out_val <= w_res;
                r_out_sat <= !w_fits;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_val, r_out_col, r_out_row};
    assign m_axis_tuser  = r_out_sat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_mac_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_mac_busy && !r_rd_vld))
        else $error("shared unit still busy while the block is ready");

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DOT) |-> (r_k <= r_len))
        else $error("dot product index ran past its length");

    a_scale_no_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE) |-> !r_rd_vld)
        else $error("store read still in flight during scaling");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a finished compute item");

    a_sat_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (r_out_val == smma_pkg::VAL_MAX || r_out_val == smma_pkg::VAL_MIN))
        else $error("clipped result is not at a range limit");

endmodule

// ===== tb/tb_scaled_matrix_multiply_accumulate.sv =====
// Self-checking testbench for the scaled matrix multiply-accumulate block.
module tb_scaled_matrix_multiply_accumulate;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM           = 32;
    localparam int NWORK         = 6;        // rows of A and columns of B kept fully loaded
    localparam int SETTLE_CYCLES = 64;       // longer than one full-length compute item
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 90;

    // One updated C element as the block should emit it.
    typedef struct packed {
        logic [smma_pkg::IDX_W-1:0]        row;
        logic [smma_pkg::IDX_W-1:0]        col;
        logic signed [smma_pkg::VAL_W-1:0] value;
        logic                              sat;
    } t_c_elem;

    typedef enum int {SINK_OPEN, SINK_JITTER, SINK_THROTTLE} t_sink_mode;

    // The scoreboard keeps its own copy of the three element stores and of the
    // registers. Loads update the copy; a compute item yields the expected
    // C element, which is written back and queued until the block emits it.
    class smma_scoreboard;
        logic signed [smma_pkg::VAL_W-1:0] a_store  [0:DIM*DIM-1];   // A, row-major
        logic signed [smma_pkg::VAL_W-1:0] bt_store [0:DIM*DIM-1];   // B transposed
        logic signed [smma_pkg::VAL_W-1:0] c_store  [0:DIM*DIM-1];   // C, row-major
        logic signed [smma_pkg::VAL_W-1:0] alpha;
        logic signed [smma_pkg::VAL_W-1:0] beta;
        logic [smma_pkg::SIZE_W-1:0]       size_in_use;
        t_c_elem                           pending_c[$];
        int                                errors;
        int                                checked;
        int                                saturated_seen;

        function new();
            int i;
            for (i = 0; i < DIM*DIM; i++) begin
                a_store[i]  = '0;
                bt_store[i] = '0;
                c_store[i]  = '0;
            end
            alpha          = smma_pkg::ALPHA_RST;
            beta           = smma_pkg::BETA_RST;
            size_in_use    = smma_pkg::SIZE_RST;
            errors         = 0;
            checked        = 0;
            saturated_seen = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        function void set_reg(smma_pkg::t_reg_idx idx, logic [smma_pkg::CFG_W-1:0] data);
            case (idx)
                smma_pkg::REG_ALPHA: alpha = data;
                smma_pkg::REG_BETA:  beta = data;
                smma_pkg::REG_SIZE:  size_in_use = data[smma_pkg::SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // beta*C + alpha*dot is exact in 64 bits; dropping 24 fraction bits with an
        // arithmetic shift truncates toward minus infinity, then the result clips.
        function t_c_elem predict_c_element(logic [smma_pkg::IDX_W-1:0] row,
                                            logic [smma_pkg::IDX_W-1:0] col);
            longint  dot;
            longint  total;
            longint  res;
            int      len;
            int      k;
            t_c_elem e;
            dot = 0;
            len = (int'(size_in_use) > DIM) ? DIM : int'(size_in_use);
            for (k = 0; k < len; k++) begin
                dot += longint'(a_store[int'(row)*DIM + k]) *
                       longint'(bt_store[int'(col)*DIM + k]);
            end
            total = dot * longint'(alpha) +
                    longint'(beta) * longint'(c_store[int'(row)*DIM + int'(col)]) * 4096;
            res   = total >>> smma_pkg::FRAC_DROP;
            e.sat = 1'b0;
            if (res > 32767) begin
                res   = 32767;
                e.sat = 1'b1;
            end else if (res < -32768) begin
                res   = -32768;
                e.sat = 1'b1;
            end
            e.row   = row;
            e.col   = col;
            e.value = res[smma_pkg::VAL_W-1:0];
            return e;
        endfunction

        function void note_item(smma_pkg::t_kind kind, logic [smma_pkg::IDX_W-1:0] row,
                                logic [smma_pkg::IDX_W-1:0] col,
                                logic signed [smma_pkg::VAL_W-1:0] value);
            t_c_elem e;
            case (kind)
                smma_pkg::KIND_LOAD_A: a_store[int'(row)*DIM + int'(col)] = value;
                smma_pkg::KIND_LOAD_B: bt_store[int'(col)*DIM + int'(row)] = value;
                smma_pkg::KIND_LOAD_C: c_store[int'(row)*DIM + int'(col)] = value;
                default: begin
                    e = predict_c_element(row, col);
                    c_store[int'(row)*DIM + int'(col)] = e.value;
                    pending_c.push_back(e);
                end
            endcase
        endfunction

        task check_c_element(logic [smma_pkg::TDATA_W-1:0] data, logic sat_flag);
            t_c_elem want;
            if (pending_c.size() == 0) begin
                report($sformatf("result row %0d col %0d with nothing outstanding",
                                 data[4:0], data[9:5]));
                return;
            end
            want = pending_c.pop_front();
            checked++;
            if (want.sat) saturated_seen++;
            if (data[4:0] !== want.row)
                report($sformatf("out_row %0d, predicted %0d", data[4:0], want.row));
            if (data[9:5] !== want.col)
                report($sformatf("out_col %0d, predicted %0d", data[9:5], want.col));
            if (data[25:10] !== want.value)
                report($sformatf("out_value %0d at (%0d,%0d), predicted %0d",
                                 $signed(data[25:10]), want.row, want.col, want.value));
            if (sat_flag !== want.sat)
                report($sformatf("saturated %b at (%0d,%0d), predicted %b",
                                 sat_flag, want.row, want.col, want.sat));
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [smma_pkg::CFG_IX_W-1:0]  i_cfg_idx     = '0;
    logic [smma_pkg::CFG_W-1:0]     i_cfg_data    = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [smma_pkg::TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [smma_pkg::KIND_W-1:0]    s_axis_tuser  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [smma_pkg::TDATA_W-1:0]   m_axis_tdata;
    logic                           m_axis_tuser;

    smma_scoreboard sb = new();

    int work_rows [NWORK];
    int work_cols [NWORK];
    int burst_left = 0;
    int n_loads    = 0;
    int n_computes = 0;
    int n_settings = 1;
    int cycles     = 0;

    // Receiver state.
    t_sink_mode sink_mode  = SINK_OPEN;
    int         mode_left  = 0;
    int         stall_hold = 0;
    logic       sink_ready = 1'b1;

    scaled_matrix_multiply_accumulate #(.DIM(DIM)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, sb.pending_c.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: check every accepted result, then pick the next tready value.
    // The receiver switches between always ready, cycle-by-cycle jitter, and long
    // stalls broken by short ready windows.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_c_element(m_axis_tdata, m_axis_tuser);
        if (mode_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 2));
            mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        case (sink_mode)
            SINK_OPEN:   m_axis_tready <= 1'b1;
            SINK_JITTER: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_hold == 0) begin
                    sink_ready = !sink_ready;
                    stall_hold = sink_ready ? $urandom_range(1, 4) : $urandom_range(5, 30);
                end else begin
                    stall_hold--;
                end
                m_axis_tready <= sink_ready;
            end
        endcase
    end

    // Mostly small Q4.12 magnitudes so that many results stay in range, with the
    // extremes and full-range values mixed in to drive saturation.
    function automatic logic signed [smma_pkg::VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 2) begin
            case ($urandom_range(0, 4))
                0: return smma_pkg::VAL_MIN;
                1: return smma_pkg::VAL_MAX;
                2: return 16'sh0000;
                3: return -16'sh0001;
                default: return 16'sh1000;
            endcase
        end
        if (sel < 17) return 16'(int'($urandom_range(0, 2047)) - 1024);
        return 16'($urandom);
    endfunction

    // Present one item and hold it until the block takes it. The sender works in
    // bursts; between bursts tvalid drops for a random number of cycles.
    task automatic send_item(smma_pkg::t_kind kind, int row, int col,
                             logic signed [smma_pkg::VAL_W-1:0] value);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'b0, value, 5'(col), 5'(row)};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(kind, 5'(row), 5'(col), value);
        if (kind == smma_pkg::KIND_COMPUTE) n_computes++;
        else n_loads++;
    endtask

    // Stop sending, let every expected result come out, then give the block time
    // to settle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending_c.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(smma_pkg::t_reg_idx idx, logic [smma_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic apply_setting(logic [smma_pkg::CFG_W-1:0] alpha,
                                 logic [smma_pkg::CFG_W-1:0] beta,
                                 logic [smma_pkg::CFG_W-1:0] size_word);
        drain_results();
        write_reg(smma_pkg::REG_ALPHA, alpha);
        write_reg(smma_pkg::REG_BETA, beta);
        write_reg(smma_pkg::REG_SIZE, size_word);
        n_settings++;
    endtask

    // Every compute item reads a whole row of A, a whole column of B and one C
    // element, so the working rows and columns are loaded completely up front.
    // Row 0 of A and column 0 of B hold the largest value, row 31 and column 31
    // the most negative one, so the four corner elements saturate both ways.
    task automatic fill_working_set();
        int i;
        int j;
        int k;
        logic signed [smma_pkg::VAL_W-1:0] v;
        for (i = 0; i < NWORK; i++) begin
            for (k = 0; k < DIM; k++) begin
                v = (i == 0) ? smma_pkg::VAL_MAX : (i == 1) ? smma_pkg::VAL_MIN : pick_value();
                send_item(smma_pkg::KIND_LOAD_A, work_rows[i], k, v);
            end
        end
        for (j = 0; j < NWORK; j++) begin
            for (k = 0; k < DIM; k++) begin
                v = (j == 0) ? smma_pkg::VAL_MAX : (j == 1) ? smma_pkg::VAL_MIN : pick_value();
                send_item(smma_pkg::KIND_LOAD_B, k, work_cols[j], v);
            end
        end
        for (i = 0; i < NWORK; i++)
            for (j = 0; j < NWORK; j++)
                send_item(smma_pkg::KIND_LOAD_C, work_rows[i], work_cols[j], pick_value());
    endtask

    task automatic run_directed();
        send_item(smma_pkg::KIND_COMPUTE, 0, 0, smma_pkg::VAL_MIN);
        send_item(smma_pkg::KIND_COMPUTE, 0, 31, smma_pkg::VAL_MAX);
        send_item(smma_pkg::KIND_COMPUTE, 31, 0, 16'sh0000);
        send_item(smma_pkg::KIND_COMPUTE, 31, 31, -16'sh0001);
        send_item(smma_pkg::KIND_LOAD_A, 31, 0, 16'sh0000);
        send_item(smma_pkg::KIND_LOAD_B, 31, 31, smma_pkg::VAL_MAX);
        send_item(smma_pkg::KIND_LOAD_C, 31, 31, -16'sh0001);
        send_item(smma_pkg::KIND_COMPUTE, 31, 31, 16'sh5555);
        send_item(smma_pkg::KIND_LOAD_A, work_rows[2], 31, smma_pkg::VAL_MAX);
        send_item(smma_pkg::KIND_LOAD_B, 0, work_cols[2], smma_pkg::VAL_MIN);
        send_item(smma_pkg::KIND_LOAD_C, work_rows[2], work_cols[2], smma_pkg::VAL_MIN);
        send_item(smma_pkg::KIND_COMPUTE, work_rows[2], work_cols[2], 16'shAAAA);
        // The same element twice in a row, then overwritten and computed again.
        send_item(smma_pkg::KIND_COMPUTE, work_rows[2], work_cols[2], 16'sh0000);
        send_item(smma_pkg::KIND_LOAD_C, work_rows[2], work_cols[2], 16'sh0001);
        send_item(smma_pkg::KIND_COMPUTE, work_rows[2], work_cols[2], 16'sh0000);
        send_item(smma_pkg::KIND_COMPUTE, work_rows[3], work_cols[4], pick_value());
        // Loads at extreme indexes with extreme values.
        send_item(smma_pkg::KIND_LOAD_A, 31, 31, smma_pkg::VAL_MIN);
        send_item(smma_pkg::KIND_LOAD_B, 0, 31, smma_pkg::VAL_MAX);
        send_item(smma_pkg::KIND_LOAD_C, 0, 31, smma_pkg::VAL_MIN);
        send_item(smma_pkg::KIND_COMPUTE, 0, 31, pick_value());
    endtask

    // Compute items (the largest share) on fully loaded rows and columns, interleaved with
    // loads that keep changing the data they read, plus loads anywhere.
    task automatic run_mixed_items(int count);
        int n;
        int sel;
        int r;
        int c;
        for (n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            r   = work_rows[$urandom_range(0, NWORK-1)];
            c   = work_cols[$urandom_range(0, NWORK-1)];
            if (sel < 45)
                send_item(smma_pkg::KIND_COMPUTE, r, c, pick_value());
            else if (sel < 60)
                send_item(smma_pkg::KIND_LOAD_A, r, $urandom_range(0, DIM-1), pick_value());
            else if (sel < 75)
                send_item(smma_pkg::KIND_LOAD_B, $urandom_range(0, DIM-1), c, pick_value());
            else if (sel < 85)
                send_item(smma_pkg::KIND_LOAD_C, r, c, pick_value());
            else
                send_item(smma_pkg::t_kind'($urandom_range(0, 2)), $urandom_range(0, DIM-1),
                          $urandom_range(0, DIM-1), pick_value());
        end
    endtask

    initial begin
        int i;
        // Rows and columns 0 and 31 are always in the working set so that every
        // index bit of the results toggles.
        work_rows[0] = 0;
        work_rows[1] = 31;
        work_cols[0] = 0;
        work_cols[1] = 31;
        for (i = 2; i < NWORK; i++) begin
            work_rows[i] = $urandom_range(1, 30);
            work_cols[i] = $urandom_range(1, 30);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of the registers: alpha 1.0, beta 0, full length.
        fill_working_set();
        run_directed();
        run_mixed_items(PHASE_ITEMS);

        // Largest positive scales with a one-term dot product.
        apply_setting(16'h7FFF, 16'h7FFF, 16'd1);
        run_mixed_items(PHASE_ITEMS);
        // Most negative scales and an empty dot product, leaving beta*C alone.
        apply_setting(16'h8000, 16'h8000, 16'd0);
        run_mixed_items(PHASE_ITEMS);
        // No product term, beta 1.0, and a length just past the matrix size.
        apply_setting(16'h0000, 16'h1000, 16'd33);
        run_mixed_items(PHASE_ITEMS);
        // Random scales with the largest length the register holds.
        apply_setting(16'($urandom), 16'($urandom), 16'd63);
        run_mixed_items(PHASE_ITEMS);
        // Upper data bits beyond the size field must be dropped, and a write to
        // the unused index must change nothing.
        apply_setting(16'h0800, 16'hF000, {10'($urandom), 6'd20});
        write_reg(smma_pkg::REG_UNUSED, 16'($urandom));
        run_mixed_items(PHASE_ITEMS);
        for (i = 0; i < 2; i++) begin
            apply_setting(pick_value(), pick_value(), 16'($urandom_range(0, 63)));
            run_mixed_items(PHASE_ITEMS);
        end
        // Plain accumulation, C = C + A*B, at full length.
        apply_setting(16'h1000, 16'h1000, 16'd32);
        run_mixed_items(PHASE_ITEMS);

        drain_results();

        $display("Covered %0d loads and %0d compute items over %0d register settings,",
                 n_loads, n_computes, n_settings);
        $display("lengths 0 to 63 and both scale extremes; %0d results checked, %0d saturated.",
                 sb.checked, sb.saturated_seen);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/smma_pkg.sv
hdl/smma_ram.sv
hdl/smma_mac.sv
hdl/scaled_matrix_multiply_accumulate.sv
tb/tb_scaled_matrix_multiply_accumulate.sv
